### hw/rtl/rtp_redundancy_packetizer_unit_assert.svh
// assertion macros for the redundancy packetizer
`ifndef RTP_REDUNDANCY_PACKETIZER_UNIT_ASSERT_SVH
`define RTP_REDUNDANCY_PACKETIZER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define RTP_ASSERT_IMP(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("rtp packetizer check failed");
`define RTP_ASSERT_NXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("rtp packetizer check failed");
`else
`define RTP_ASSERT_IMP(label, clk, rst, pre, post)
`define RTP_ASSERT_NXT(label, clk, rst, pre, post)
`endif

`endif

### hw/rtl/rtp_pkg.sv
// shared types and constants of the redundancy packetizer
package rtp_pkg;

   localparam int MAX_FRAME_BYTES_DEF = 256;
   localparam int STAMP_W = 14;
   localparam int LEN_FIELD_W = 10;
   localparam int PT_W = 7;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_DRAIN = 1'b1;

   localparam logic REG_REDUNDANCY_LEVEL = 1'b0;
   localparam logic REG_PAYLOAD_TYPE = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_HDR0,
      ST_HDR1,
      ST_HDR2,
      ST_HDR3,
      ST_FINAL,
      ST_PREV,
      ST_CUR
   } seq_state_type;

   typedef struct packed {
      logic       valid;
      logic       use_ram;
      logic [7:0] hdr_byte;
      logic       last;
   } stage_type;

endpackage

### hw/rtl/rtp_redundancy_packetizer_unit.sv
// a drain word's result word passes through the stage register, with the frame store
// read at the accepting edge, and then through the output register
// throughput: one word per cycle unless the output stalls, loads and drains alike
// reset is synchronous; it clears control state and config, the frame store
// is not cleared and has no clearing pass
`include "rtp_redundancy_packetizer_unit_assert.svh"

module rtp_redundancy_packetizer_unit import rtp_pkg::*; #(
   parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_opcode,
   input  logic [7:0]  req_data_byte,
   input  logic        req_frame_last,
   input  logic [31:0] req_frame_stamp,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_packet_last,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [6:0]  csr_wdata
);

   localparam int DEPTH = 2 * MAX_FRAME_BYTES;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic              redundancy_level_ff;
   logic [PT_W-1:0]   payload_type_ff;
   logic              rsp_valid_ff;
   logic [7:0]        rsp_out_byte_ff;
   logic              rsp_packet_last_ff;

   logic              go;
   logic              out_free;
   logic              pending;
   logic              csr_take;
   logic              prev_clear;
   stage_type         stage;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [7:0]        wr_data;
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic [7:0]        rd_data;

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign req_ready  = !stage.valid || out_free;
   assign go         = req_valid && req_ready;
   assign csr_take   = csr_we && !pending;
   assign prev_clear = csr_take && (csr_index == REG_REDUNDANCY_LEVEL);

   // config is ignored while a packet is pending
   always_ff @(posedge clock) begin
      if (reset) begin
         redundancy_level_ff <= 1'b1;
         payload_type_ff     <= '0;
      end else if (csr_take) begin
         case (csr_index)
            REG_REDUNDANCY_LEVEL: redundancy_level_ff <= csr_wdata[0];
            REG_PAYLOAD_TYPE:     payload_type_ff <= csr_wdata;
            default:              payload_type_ff <= payload_type_ff;
         endcase
      end
   end

   rtp_seq #(
      .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
   ) u_seq (
      .clock           (clock),
      .reset           (reset),
      .go              (go),
      .stage_load      (req_ready),
      .req_opcode      (req_opcode),
      .req_data_byte   (req_data_byte),
      .req_frame_last  (req_frame_last),
      .stamp_low       (req_frame_stamp[STAMP_W-1:0]),
      .redundancy_level(redundancy_level_ff),
      .payload_type    (payload_type_ff),
      .prev_clear      (prev_clear),
      .pending         (pending),
      .stage           (stage),
      .wr_en           (wr_en),
      .wr_addr         (wr_addr),
      .wr_data         (wr_data),
      .rd_en           (rd_en),
      .rd_addr         (rd_addr)
   );

   rtp_ram #(
      .WIDTH(8),
      .DEPTH(DEPTH)
   ) u_store (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= stage.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && stage.valid) begin
         rsp_out_byte_ff    <= stage.use_ram ? rd_data : stage.hdr_byte;
         rsp_packet_last_ff <= stage.last;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_byte    = rsp_out_byte_ff;
   assign rsp_packet_last = rsp_packet_last_ff;

   `RTP_ASSERT_NXT(a_drain_idle_no_word, clock, reset,
      go && (req_opcode == OP_DRAIN) && !pending, !stage.valid)
   `RTP_ASSERT_IMP(a_last_word_closes, clock, reset,
      stage.valid && stage.last, !pending)
   `RTP_ASSERT_NXT(a_csr_held_when_pending, clock, reset,
      csr_we && pending, $stable(payload_type_ff) && $stable(redundancy_level_ff))
   `RTP_ASSERT_IMP(a_stall_only_when_full, clock, reset,
      !req_ready, stage.valid && rsp_valid_ff)

endmodule

### hw/rtl/rtp_ram.sv
// generic single-port-write ram with registered read
module rtp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 512,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/rtp_seq.sv
// frame bookkeeping, payload sequencer and first result stage
module rtp_seq import rtp_pkg::*; #(
   parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF,
   localparam int ADDR_W = (2 * MAX_FRAME_BYTES > 1) ? $clog2(2 * MAX_FRAME_BYTES) : 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              go,
   input  logic              stage_load,
   input  logic              req_opcode,
   input  logic [7:0]        req_data_byte,
   input  logic              req_frame_last,
   input  logic [STAMP_W-1:0] stamp_low,
   input  logic              redundancy_level,
   input  logic [PT_W-1:0]   payload_type,
   input  logic              prev_clear,
   output logic              pending,
   output stage_type         stage,
   output logic              wr_en,
   output logic [ADDR_W-1:0] wr_addr,
   output logic [7:0]        wr_data,
   output logic              rd_en,
   output logic [ADDR_W-1:0] rd_addr
);

   localparam int LEN_W = $clog2(MAX_FRAME_BYTES + 1);
   localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_FRAME_BYTES);
   localparam logic [ADDR_W-1:0] BANK_BASE = ADDR_W'(MAX_FRAME_BYTES);

   seq_state_type       state_ff, state_in;
   logic                bank_ff, bank_in;
   logic [LEN_W-1:0]    cur_len_ff, cur_len_in;
   logic [LEN_W-1:0]    prev_len_ff, prev_len_in;
   logic [LEN_W-1:0]    idx_ff, idx_in;
   logic [STAMP_W-1:0]  cur_stamp_ff, cur_stamp_in;
   logic [STAMP_W-1:0]  prev_stamp_ff, prev_stamp_in;
   logic                prev_valid_ff, prev_valid_in;
   logic                with_red_ff, with_red_in;
   stage_type           stage_ff, stage_in;

   logic                load_go;
   logic                drain_go;
   logic                red_now;
   logic                rd_bank;
   logic [LEN_W-1:0]    idx_next;
   logic [STAMP_W-1:0]  offset;
   logic [LEN_FIELD_W-1:0] plen;

   assign load_go  = go && (req_opcode == OP_LOAD) && (state_ff == ST_IDLE);
   assign drain_go = go && (req_opcode == OP_DRAIN) && (state_ff != ST_IDLE);
   assign red_now  = redundancy_level && prev_valid_ff;
   assign idx_next = idx_ff + LEN_W'(1);
   assign offset   = cur_stamp_ff - prev_stamp_ff;
   assign plen     = LEN_FIELD_W'(prev_len_ff);

   assign rd_bank = (state_ff == ST_PREV) ? ~bank_ff : bank_ff;
   assign rd_addr = rd_bank ? (BANK_BASE + ADDR_W'(idx_ff)) : ADDR_W'(idx_ff);
   assign wr_addr = bank_ff ? (BANK_BASE + ADDR_W'(cur_len_ff)) : ADDR_W'(cur_len_ff);
   assign wr_data = req_data_byte;

   always_comb begin
      state_in      = state_ff;
      bank_in       = bank_ff;
      cur_len_in    = cur_len_ff;
      prev_len_in   = prev_len_ff;
      idx_in        = idx_ff;
      cur_stamp_in  = cur_stamp_ff;
      prev_stamp_in = prev_stamp_ff;
      prev_valid_in = prev_valid_ff;
      with_red_in   = with_red_ff;
      stage_in      = '0;
      wr_en         = 1'b0;
      rd_en         = 1'b0;

      if (load_go) begin
         if (cur_len_ff < MAX_LEN) begin
            wr_en      = 1'b1;
            cur_len_in = cur_len_ff + LEN_W'(1);
         end
         if (req_frame_last) begin
            cur_stamp_in = stamp_low;
            with_red_in  = red_now;
            idx_in       = '0;
            state_in     = red_now ? ST_HDR0 : ST_FINAL;
         end
      end

      if (prev_clear) begin
         prev_valid_in = 1'b0;
      end

      if (drain_go) begin
         stage_in.valid = 1'b1;
         case (state_ff)
            ST_HDR0: begin
               stage_in.hdr_byte = {1'b1, payload_type};
               state_in = ST_HDR1;
            end
            ST_HDR1: begin
               stage_in.hdr_byte = offset[13:6];
               state_in = ST_HDR2;
            end
            ST_HDR2: begin
               stage_in.hdr_byte = {offset[5:0], plen[9:8]};
               state_in = ST_HDR3;
            end
            ST_HDR3: begin
               stage_in.hdr_byte = plen[7:0];
               state_in = ST_FINAL;
            end
            ST_FINAL: begin
               stage_in.hdr_byte = {1'b0, payload_type};
               idx_in = '0;
               state_in = with_red_ff ? ST_PREV : ST_CUR;
            end
            ST_PREV: begin
               stage_in.use_ram = 1'b1;
               rd_en = 1'b1;
               if (idx_next == prev_len_ff) begin
                  idx_in   = '0;
                  state_in = ST_CUR;
               end else begin
                  idx_in = idx_next;
               end
            end
            ST_CUR: begin
               stage_in.use_ram = 1'b1;
               rd_en = 1'b1;
               if (idx_next == cur_len_ff) begin
                  // packet done: current frame becomes the stored one
                  stage_in.last = 1'b1;
                  prev_len_in   = cur_len_ff;
                  prev_stamp_in = cur_stamp_ff;
                  prev_valid_in = 1'b1;
                  bank_in       = ~bank_ff;
                  cur_len_in    = '0;
                  idx_in        = '0;
                  state_in      = ST_IDLE;
               end else begin
                  idx_in = idx_next;
               end
            end
            default: begin
               stage_in = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         bank_ff       <= 1'b0;
         cur_len_ff    <= '0;
         prev_len_ff   <= '0;
         idx_ff        <= '0;
         cur_stamp_ff  <= '0;
         prev_stamp_ff <= '0;
         prev_valid_ff <= 1'b0;
         with_red_ff   <= 1'b0;
         stage_ff      <= '0;
      end else begin
         state_ff      <= state_in;
         bank_ff       <= bank_in;
         cur_len_ff    <= cur_len_in;
         prev_len_ff   <= prev_len_in;
         idx_ff        <= idx_in;
         cur_stamp_ff  <= cur_stamp_in;
         prev_stamp_ff <= prev_stamp_in;
         prev_valid_ff <= prev_valid_in;
         with_red_ff   <= with_red_in;
         if (stage_load) begin
            stage_ff <= stage_in;
         end
      end
   end

   assign pending = (state_ff != ST_IDLE);
   assign stage   = stage_ff;

endmodule
